[design/kmsd_pkg.sv]
// ----------------------------------------------------------------------------
// kmsd_pkg
// Shared constants and types for the key matrix scan and debounce block.
// ----------------------------------------------------------------------------
package kmsd_pkg;

	localparam int NUM_COLUMNS = 5;
	localparam int NUM_ROWS    = 6;
	localparam int NUM_KEYS    = NUM_COLUMNS * NUM_ROWS;
	localparam int COL_W       = 3;
	localparam int DRIVE_W     = 5;
	localparam int HOLD_W      = 8;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [ADDR_W-3:0] REG_HOLD_SCANS = '0;
	localparam logic [HOLD_W-1:0] HOLD_RESET     = 8'd20;

	typedef struct packed {
		logic                last;
		logic [NUM_KEYS-1:0] raw;
	} scan_t;

endpackage

[design/kmsd_if.sv]
// ----------------------------------------------------------------------------
// kmsd_row_if / kmsd_key_if
// Valid/ready channels for row reads and debounced key results.
// ----------------------------------------------------------------------------
interface kmsd_row_if;
	logic                      valid;
	logic                      ready;
	logic [kmsd_pkg::NUM_ROWS-1:0] row_levels;

	modport source (output valid, output row_levels, input ready);
	modport sink (input valid, input row_levels, output ready);
endinterface

interface kmsd_key_if;
	logic                          valid;
	logic                          ready;
	logic [kmsd_pkg::DRIVE_W-1:0]  column_drive;
	logic [kmsd_pkg::NUM_KEYS-1:0] keys_pressed;
	logic                          scan_done;

	modport source (output valid, output column_drive, output keys_pressed,
		output scan_done, input ready);
	modport sink (input valid, input column_drive, input keys_pressed,
		input scan_done, output ready);
endinterface

[design/kmsd_cfg.sv]
// ----------------------------------------------------------------------------
// kmsd_cfg
// APB register port holding the debounce hold period.
// ----------------------------------------------------------------------------
module kmsd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kmsd_pkg::ADDR_W-1:0]   paddr,
	input  logic [kmsd_pkg::DATA_W-1:0]   pwdata,
	output logic [kmsd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [kmsd_pkg::HOLD_W-1:0]   hold_scans
);
	import kmsd_pkg::*;

	logic [HOLD_W-1:0] hold_q;
	logic              sel_hold;

	assign sel_hold   = (paddr[ADDR_W-1:2] == REG_HOLD_SCANS);
	assign pready     = 1'b1;
	assign hold_scans = hold_q;
	assign prdata     = sel_hold ? DATA_W'(hold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (psel && penable && pwrite && sel_hold) begin
			hold_q <= pwdata[HOLD_W-1:0];
		end
	end

endmodule

[design/kmsd_scan.sv]
// ----------------------------------------------------------------------------
// kmsd_scan
// Column sequencer and raw key accumulator for one matrix scan.
// ----------------------------------------------------------------------------
module kmsd_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [kmsd_pkg::NUM_ROWS-1:0] row_levels,
	output kmsd_pkg::scan_t               scan,
	output logic [kmsd_pkg::DRIVE_W-1:0]  column_drive
);
	import kmsd_pkg::*;

	logic [COL_W-1:0]    col_q;
	logic [COL_W-1:0]    col_nxt;
	logic [NUM_KEYS-1:0] raw_q;
	logic [NUM_ROWS-1:0] pressed;

	always_comb begin
		pressed  = ~row_levels;
		scan.raw = raw_q;
		for (int c = 0; c < NUM_COLUMNS; c++) begin
			if (col_q == COL_W'(c)) begin
				scan.raw[c*NUM_ROWS +: NUM_ROWS] = raw_q[c*NUM_ROWS +: NUM_ROWS] | pressed;
			end
		end
		scan.last    = (col_q >= COL_W'(NUM_COLUMNS - 1));
		col_nxt      = scan.last ? '0 : col_q + COL_W'(1);
		column_drive = ~(DRIVE_W'(1) << col_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			raw_q <= '0;
		end else if (en) begin
			col_q <= col_nxt;
			raw_q <= scan.last ? '0 : scan.raw;
		end
	end

endmodule

[design/kmsd_debounce.sv]
// ----------------------------------------------------------------------------
// kmsd_debounce
// Per-key hold counters and debounced key vector, updated once per scan.
// ----------------------------------------------------------------------------
module kmsd_debounce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  kmsd_pkg::scan_t               scan,
	input  logic [kmsd_pkg::HOLD_W-1:0]   hold_scans,
	output logic [kmsd_pkg::NUM_KEYS-1:0] keys
);
	import kmsd_pkg::*;

	logic [HOLD_W-1:0]   cnt_q   [NUM_KEYS];
	logic [HOLD_W-1:0]   cnt_nxt [NUM_KEYS];
	logic [NUM_KEYS-1:0] keys_q;
	logic [NUM_KEYS-1:0] keys_nxt;

	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (cnt_q[k] == '0) begin
				keys_nxt[k] = scan.raw[k];
				cnt_nxt[k]  = scan.raw[k] ? hold_scans : '0;
			end else begin
				keys_nxt[k] = keys_q[k];
				cnt_nxt[k]  = cnt_q[k] - HOLD_W'(1);
			end
		end
		keys = scan.last ? keys_nxt : keys_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= '0;
			for (int k = 0; k < NUM_KEYS; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (en && scan.last) begin
			keys_q <= keys_nxt;
			for (int k = 0; k < NUM_KEYS; k++) begin
				cnt_q[k] <= cnt_nxt[k];
			end
		end
	end

endmodule

[design/key_matrix_scan_debounce.sv]
// ----------------------------------------------------------------------------
// key_matrix_scan_debounce
// Scans a 5 x 6 key matrix one column per transaction and debounces keys.
//
// rows: one transaction per column read, carrying the active-low row levels
//   sampled while the current column is driven low. Column 0 is driven first.
// keys: one transaction per row transaction, with the active-low drive for
//   the next column, the debounced key vector and scan_done on the last column.
// APB: register 0 at address 0 holds hold_scans (reset 20); write only idle.
// Path: an accepted row read goes to the input register, then to the result
//   register. Throughput: 1 transaction per cycle while keys.ready is high;
//   all 30 hold counters update in parallel in the same cycle as the last column.
// Reset: column 0, empty raw vector, all counters and keys cleared; no
//   clearing pass.
// Stall: results hold in the result register while keys.ready is low; one more
//   transaction waits in the input register, then rows.ready drops.
// ----------------------------------------------------------------------------
module key_matrix_scan_debounce (
	input  logic                          clk,
	input  logic                          arst_n,
	kmsd_row_if.sink                      rows,
	kmsd_key_if.source                    keys,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kmsd_pkg::ADDR_W-1:0]   paddr,
	input  logic [kmsd_pkg::DATA_W-1:0]   pwdata,
	output logic [kmsd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import kmsd_pkg::*;

	logic                valid_s1;
	logic [NUM_ROWS-1:0] row_s1;
	logic                valid_s2;
	logic [DRIVE_W-1:0]  drive_s2;
	logic [NUM_KEYS-1:0] keys_s2;
	logic                done_s2;

	logic                advance;
	logic                load_s1;
	logic [HOLD_W-1:0]   hold_scans;
	scan_t               scan;
	logic [DRIVE_W-1:0]  drive_nxt;
	logic [NUM_KEYS-1:0] keys_nxt;

	assign advance    = valid_s1 && (!valid_s2 || keys.ready);
	assign rows.ready = !valid_s1 || advance;
	assign load_s1    = rows.valid && rows.ready;

	kmsd_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.hold_scans (hold_scans)
	);

	kmsd_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.row_levels   (row_s1),
		.scan         (scan),
		.column_drive (drive_nxt)
	);

	kmsd_debounce u_debounce (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.scan       (scan),
		.hold_scans (hold_scans),
		.keys       (keys_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (keys.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			row_s1 <= rows.row_levels;
		end
		if (advance) begin
			drive_s2 <= drive_nxt;
			keys_s2  <= keys_nxt;
			done_s2  <= scan.last;
		end
	end

	assign keys.valid        = valid_s2;
	assign keys.column_drive = drive_s2;
	assign keys.keys_pressed = keys_s2;
	assign keys.scan_done    = done_s2;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for key_matrix_scan_debounce. Row reads are pushed
// from a queue through a random-idling driver. Each accepted read updates a
// local scan and debounce predictor. Key results are checked field by field
// against it while the key side stalls at random. hold_scans is rewritten
// between phases, with the block drained first.
// ----------------------------------------------------------------------------
module testbench;
	import kmsd_pkg::*;

	typedef struct {
		logic [DRIVE_W-1:0]  column_drive;
		logic [NUM_KEYS-1:0] keys_pressed;
		logic                scan_done;
	} key_result_t;

	logic                clk;
	logic                arst_n;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [ADDR_W-1:0]   paddr   = '0;
	logic [DATA_W-1:0]   pwdata  = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	kmsd_row_if rows_ch ();
	kmsd_key_if keys_ch ();

	key_matrix_scan_debounce DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.rows    (rows_ch),
		.keys    (keys_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [NUM_ROWS-1:0] row_reads[$];
	key_result_t         predicted_keys[$];
	int                  mismatches = 0;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;

	// scanner state as the block should hold it
	logic [HOLD_W-1:0]   hold_scans_cfg = HOLD_RESET;
	int                  scan_col = 0;
	logic [NUM_KEYS-1:0] raw_keys = '0;
	logic [NUM_KEYS-1:0] held_keys = '0;
	logic [HOLD_W-1:0]   hold_left[NUM_KEYS];

	// stimulus-side view of the matrix
	int                  gen_col = 0;
	logic [NUM_KEYS-1:0] matrix = '0;

	key_result_t         got;
	key_result_t         want;

	initial begin
		foreach (hold_left[k])
			hold_left[k] = '0;
	end

	function automatic void scan_column(input logic [NUM_ROWS-1:0] levels);
		logic [NUM_KEYS-1:0] pressed;
		logic                last;
		int                  nxt;
		key_result_t         r;
		pressed = {{(NUM_KEYS-NUM_ROWS){1'b0}}, ~levels};
		last = (scan_col >= NUM_COLUMNS - 1);
		if (scan_col < NUM_COLUMNS)
			raw_keys |= pressed << (scan_col * NUM_ROWS);
		if (last) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (hold_left[k] == '0) begin
					held_keys[k] = raw_keys[k];
					if (raw_keys[k])
						hold_left[k] = hold_scans_cfg;
				end else begin
					hold_left[k] = hold_left[k] - 1'b1;
				end
			end
			raw_keys = '0;
			nxt = 0;
		end else begin
			nxt = scan_col + 1;
		end
		scan_col = nxt;
		r.column_drive = ~(DRIVE_W'(1) << nxt);
		r.keys_pressed = held_keys;
		r.scan_done = last;
		predicted_keys.push_back(r);
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		rows_ch.valid = 1'b0;
		rows_ch.row_levels = '0;
		keys_ch.ready = 1'b0;
		fork
			forever #5 clk = ~clk;
			begin
				repeat (6) @(posedge clk);
				arst_n <= 1'b1;
			end
		join
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// row driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (rows_ch.valid && rows_ch.ready)
				scan_column(rows_ch.row_levels);
			if (!rows_ch.valid || rows_ch.ready) begin
				if (row_reads.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					rows_ch.valid <= 1'b1;
					rows_ch.row_levels <= row_reads.pop_front();
				end else begin
					rows_ch.valid <= 1'b0;
				end
			end
		end
	end

	// key monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (keys_ch.valid && keys_ch.ready) begin
				got.column_drive = keys_ch.column_drive;
				got.keys_pressed = keys_ch.keys_pressed;
				got.scan_done = keys_ch.scan_done;
				if (predicted_keys.size() == 0) begin
					$error("key transaction with no row read outstanding");
					mismatches++;
				end else begin
					want = predicted_keys.pop_front();
					if (got.column_drive !== want.column_drive) begin
						$error("column_drive: expected %h, got %h",
							want.column_drive, got.column_drive);
						mismatches++;
					end
					if (got.keys_pressed !== want.keys_pressed) begin
						$error("keys_pressed: expected %h, got %h",
							want.keys_pressed, got.keys_pressed);
						mismatches++;
					end
					if (got.scan_done !== want.scan_done) begin
						$error("scan_done: expected %b, got %b",
							want.scan_done, got.scan_done);
						mismatches++;
					end
				end
			end
			keys_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic queue_row(input logic [NUM_ROWS-1:0] levels);
		row_reads.push_back(levels);
		gen_col = (gen_col == NUM_COLUMNS - 1) ? 0 : gen_col + 1;
	endtask

	// mostly clean scans of a slowly changing matrix, some bounce noise
	task automatic queue_random(input int count);
		logic [NUM_KEYS-1:0] flips;
		logic [NUM_ROWS-1:0] levels;
		for (int i = 0; i < count; i++) begin
			if (gen_col == 0) begin
				flips = NUM_KEYS'($urandom & $urandom & $urandom);
				matrix ^= flips;
			end
			if ($urandom_range(9) == 0)
				levels = NUM_ROWS'($urandom_range(63));
			else
				levels = ~matrix[gen_col*NUM_ROWS +: NUM_ROWS];
			queue_row(levels);
		end
	endtask

	task automatic set_idle(input int phase);
		case (phase / 2)
			0: begin
				send_idle_pct = 19;
				recv_idle_pct = 80;
			end
			1: begin
				send_idle_pct = 80;
				recv_idle_pct = 19;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (row_reads.size() != 0 || rows_ch.valid || predicted_keys.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_hold_scans(input logic [HOLD_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_HOLD_SCANS, 2'b00};
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		hold_scans_cfg = value;
	endtask

	initial begin
		wait (arst_n === 1'b1);

		set_idle(0);
		repeat (NUM_COLUMNS) queue_row('0);
		repeat (NUM_COLUMNS) queue_row('1);
		queue_row(6'h2A);
		queue_row(6'h15);
		queue_row(6'h2A);
		queue_random(60);
		wait_drained();

		// hold off: start mid-scan
		write_hold_scans('0);
		set_idle(1);
		queue_row(6'h15);
		queue_row(6'h3E);
		repeat (NUM_COLUMNS) queue_row('1);
		queue_random(80);
		wait_drained();

		write_hold_scans(8'd1);
		set_idle(2);
		queue_random(80);
		wait_drained();

		write_hold_scans(8'd3);
		set_idle(3);
		queue_random(80);
		wait_drained();

		write_hold_scans(HOLD_W'($urandom_range(2, 7)));
		set_idle(4);
		queue_random(60);
		wait_drained();

		write_hold_scans('1);
		set_idle(5);
		repeat (NUM_COLUMNS) queue_row('0);
		queue_random(40);
		wait_drained();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && predicted_keys.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
